@@ hw/rtl/ammd_pkg.sv @@
package ammd_pkg;

    // Field widths fixed by the sample and register formats.
    localparam int SAMPLE_W  = 13;
    localparam int LIMIT_W   = 13;
    localparam int PERIOD_W  = 8;
    localparam int PREC_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Default lane count.
    localparam int AMMD_AXES = 3;
    localparam int MAX_AXES  = 3;

    // Moving average over the current sample and three stored taps.
    localparam int AVG_TAPS  = 4;
    localparam int HIST_TAPS = AVG_TAPS - 1;
    localparam int SUM_W     = SAMPLE_W + 2;

    // Running extreme restart values.
    localparam logic signed [SAMPLE_W-1:0] MAX_START = '0;
    localparam logic signed [SAMPLE_W-1:0] MIN_START = 13'sh0FFF;

    // Precision constants. Swing / 50 is done as (swing * 5243) >> 18,
    // exact for any swing below 8192.
    localparam logic [PREC_W-1:0] PREC_MID  = 8'd3;
    localparam logic [PREC_W-1:0] PREC_WEAK = 8'd2;
    localparam int               RECIP_SH  = 18;
    localparam logic [12:0]      RECIP_50  = 13'd5243;

    // Register reset values.
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd50;
    localparam logic [LIMIT_W-1:0]  HIGH_RST   = 13'd250;
    localparam logic [LIMIT_W-1:0]  MID_RST    = 13'd100;
    localparam logic [LIMIT_W-1:0]  SPORT_RST  = 13'd500;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 2'd0,
        CFG_HIGH   = 2'd1,
        CFG_MID    = 2'd2,
        CFG_SPORT  = 2'd3
    } t_cfg_idx;

    // Swing limits handed to every lane.
    typedef struct packed {
        logic [LIMIT_W-1:0] high;
        logic [LIMIT_W-1:0] mid;
        logic [LIMIT_W-1:0] sport;
    } t_limits;

    // What one lane found for the word in its second stage.
    typedef struct packed {
        logic crossed;
        logic sport;
    } t_lane_hit;

    // One result word.
    typedef struct packed {
        logic motion_state;
        logic crossing_seen;
        logic period_end;
    } t_result;

endpackage

@@ hw/rtl/ammd_sample_if.sv @@
interface ammd_sample_if
    import ammd_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic signed [SAMPLE_W-1:0] z_sample;

    modport source (output valid, output x_sample, output y_sample, output z_sample,
                    input ready);
    modport sink   (input valid, input x_sample, input y_sample, input z_sample,
                    output ready);
endinterface

@@ hw/rtl/ammd_result_if.sv @@
interface ammd_result_if;
    logic valid;
    logic ready;
    logic motion_state;
    logic crossing_seen;
    logic period_end;

    modport source (output valid, output motion_state, output crossing_seen,
                    output period_end, input ready);
    modport sink   (input valid, input motion_state, input crossing_seen,
                    input period_end, output ready);
endinterface

@@ hw/rtl/ammd_lane.sv @@
module ammd_lane
    import ammd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s1_load,
    input  logic                       i_s1_close,
    input  logic signed [SAMPLE_W-1:0] i_raw,
    input  logic                       i_s2_load,
    input  logic                       i_s2_close,
    input  t_limits                    i_limits,
    output t_lane_hit                  o_hit
);

    // Stage one: history taps, smoothing and running extremes.
    logic signed [SAMPLE_W-1:0] r_tap [HIST_TAPS];
    logic signed [SAMPLE_W-1:0] r_max;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SUM_W-1:0]    w_sum_adj;
    logic signed [SAMPLE_W-1:0] w_smooth;
    logic signed [SAMPLE_W-1:0] n_max;
    logic signed [SAMPLE_W-1:0] n_min;

    always_comb begin
        w_sum = SUM_W'(i_raw);
        for (int t = 0; t < HIST_TAPS; t++) begin
            w_sum = w_sum + SUM_W'(r_tap[t]);
        end
        // Divide by four, truncating toward zero.
        w_sum_adj = w_sum + (w_sum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
        w_smooth  = w_sum_adj[SUM_W-1:2];
        n_max     = (w_smooth > r_max) ? w_smooth : r_max;
        n_min     = (w_smooth < r_min) ? w_smooth : r_min;
    end

    // Stage one registers handed to stage two.
    logic signed [SAMPLE_W-1:0] r_s1_raw;
    logic signed [SAMPLE_W-1:0] r_s1_smooth;
    logic signed [SAMPLE_W-1:0] r_s1_max;
    logic signed [SAMPLE_W-1:0] r_s1_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < HIST_TAPS; t++) begin
                r_tap[t] <= '0;
            end
            r_max <= MAX_START;
            r_min <= MIN_START;
        end else if (i_s1_load) begin
            for (int t = HIST_TAPS - 1; t > 0; t--) begin
                r_tap[t] <= r_tap[t-1];
            end
            r_tap[0] <= i_raw;
            r_max    <= i_s1_close ? MAX_START : n_max;
            r_min    <= i_s1_close ? MIN_START : n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_load) begin
            r_s1_raw    <= i_raw;
            r_s1_smooth <= w_smooth;
            r_s1_max    <= n_max;
            r_s1_min    <= n_min;
        end
    end

    // Stage two: threshold latch for a closing word, then crossing test.
    logic [LIMIT_W-1:0]         r_swing;
    logic signed [SAMPLE_W-1:0] r_mid;
    logic [PREC_W-1:0]          r_prec;
    logic                       r_weak;

    logic signed [SAMPLE_W:0]   w_swing_s;
    logic [LIMIT_W-1:0]         w_swing_new;
    logic signed [SAMPLE_W:0]   w_mid_sum;
    logic signed [SAMPLE_W:0]   w_mid_adj;
    logic signed [SAMPLE_W-1:0] w_mid_new;
    logic [2*LIMIT_W-1:0]       w_prod;
    logic [PREC_W-1:0]          w_prec_new;
    logic                       w_weak_new;

    logic [LIMIT_W-1:0]         w_swing;
    logic signed [SAMPLE_W-1:0] w_mid;
    logic [PREC_W-1:0]          w_prec;
    logic                       w_weak;
    logic signed [SAMPLE_W:0]   w_diff;
    logic [SAMPLE_W:0]          w_mag;
    logic signed [SAMPLE_W-1:0] w_tracked;

    always_comb begin
        // The swing never goes negative: min <= smoothed <= max after one word.
        w_swing_s   = (SAMPLE_W+1)'(r_s1_max) - (SAMPLE_W+1)'(r_s1_min);
        w_swing_new = w_swing_s[LIMIT_W-1:0];
        w_mid_sum   = (SAMPLE_W+1)'(r_s1_max) + (SAMPLE_W+1)'(r_s1_min);
        w_mid_adj   = w_mid_sum + (w_mid_sum[SAMPLE_W] ? (SAMPLE_W+1)'(1)
                                                       : (SAMPLE_W+1)'(0));
        w_mid_new   = w_mid_adj[SAMPLE_W:1];
        w_prod      = (2*LIMIT_W)'(w_swing_new) * (2*LIMIT_W)'(RECIP_50);
        w_weak_new  = 1'b0;
        if (w_swing_new >= i_limits.high) begin
            w_prec_new = w_prod[RECIP_SH +: PREC_W];
        end else if (w_swing_new >= i_limits.mid) begin
            w_prec_new = PREC_MID;
        end else begin
            w_prec_new = PREC_WEAK;
            w_weak_new = 1'b1;
        end

        w_swing = i_s2_close ? w_swing_new : r_swing;
        w_mid   = i_s2_close ? w_mid_new   : r_mid;
        w_prec  = i_s2_close ? w_prec_new  : r_prec;
        w_weak  = i_s2_close ? w_weak_new  : r_weak;

        w_diff    = (SAMPLE_W+1)'(r_s1_smooth) - (SAMPLE_W+1)'(r_s1_raw);
        w_mag     = w_diff[SAMPLE_W] ? $unsigned(-w_diff) : $unsigned(w_diff);
        w_tracked = (w_mag > (SAMPLE_W+1)'(w_prec)) ? r_s1_smooth : r_s1_raw;

        o_hit.crossed = (r_s1_raw > w_mid) && (w_tracked < w_mid) && !w_weak;
        o_hit.sport   = (w_swing >= i_limits.sport);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swing <= '0;
            r_mid   <= '0;
            r_prec  <= '0;
            r_weak  <= 1'b0;
        end else if (i_s2_load && i_s2_close) begin
            r_swing <= w_swing_new;
            r_mid   <= w_mid_new;
            r_prec  <= w_prec_new;
            r_weak  <= w_weak_new;
        end
    end

endmodule

@@ hw/rtl/ammd_merge.sv @@
module ammd_merge
    import ammd_pkg::*;
#(
    parameter int AXES = AMMD_AXES
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  logic      i_close,
    input  t_lane_hit i_hit [AXES],
    output t_result   o_result
);

    logic    r_motion;
    t_result r_result;
    logic    n_motion;
    logic    w_any;

    // The highest-numbered crossing lane decides the motion state.
    always_comb begin
        n_motion = r_motion;
        w_any    = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            if (i_hit[a].crossed) begin
                w_any    = 1'b1;
                n_motion = i_hit[a].sport;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion <= 1'b0;
        end else if (i_load) begin
            r_motion <= n_motion;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result.motion_state  <= n_motion;
            r_result.crossing_seen <= w_any;
            r_result.period_end    <= i_close;
        end
    end

    assign o_result = r_result;

endmodule

@@ hw/rtl/accel_motion_threshold_detector.sv @@
// Motion threshold detector for a three-axis accelerometer.
//
// Input channel i_sample carries one word per sample with the signed
// x_sample, y_sample and z_sample fields. Output channel o_result carries
// one word per sample: motion_state, crossing_seen and period_end. Both
// use valid/ready; a word moves on a rising edge with both high.
// Registers are written through i_cfg_we, i_cfg_index and i_cfg_data:
// period length, then the high, mid and sport limits. The user must write
// them only while the block is idle; the block does not enforce this.
// A sample passes two register stages: smoothing and running extremes in
// the first, threshold latch, crossing test and lane merge in the second.
// The sample is registered into the first stage, then its result word into
// the output register, from which it leaves when taken; one sample is
// taken every cycle while the output side keeps up.
// When the receiver stalls, the result word holds in the output register
// and the first stage keeps one more sample before ready drops.
// Reset clears the taps, thresholds, sample count and motion state, restarts the extremes
// and restores the register defaults; no results are pending.
module accel_motion_threshold_detector
    import ammd_pkg::*;
#(
    parameter int AXES = AMMD_AXES
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    ammd_sample_if.sink          i_sample,
    ammd_result_if.source        o_result
);

    // Configuration registers.
    logic [PERIOD_W-1:0] r_period;
    t_limits             r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period       <= PERIOD_RST;
            r_limits.high  <= HIGH_RST;
            r_limits.mid   <= MID_RST;
            r_limits.sport <= SPORT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD: r_period       <= i_cfg_data[PERIOD_W-1:0];
                CFG_HIGH:   r_limits.high  <= i_cfg_data;
                CFG_MID:    r_limits.mid   <= i_cfg_data;
                CFG_SPORT:  r_limits.sport <= i_cfg_data;
                default:    r_limits       <= r_limits;
            endcase
        end
    end

    // Pipeline handshake: the output stage advances when the output word is
    // empty or being taken; the first stage also loads while it is empty.
    logic r_s1_valid;
    logic r_s1_close;
    logic r_out_valid;
    logic w_out_adv;
    logic w_s1_load;
    logic w_s2_load;

    assign w_out_adv      = !r_out_valid || o_result.ready;
    assign i_sample.ready = !r_s1_valid || w_out_adv;
    assign w_s1_load      = i_sample.valid && i_sample.ready;
    assign w_s2_load      = r_s1_valid && w_out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_s1_valid <= i_sample.valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Sample count and period close.
    logic [PERIOD_W-1:0] r_count;
    logic [PERIOD_W-1:0] n_count;
    logic                w_close;

    assign n_count = r_count + PERIOD_W'(1);
    assign w_close = (n_count >= r_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_s1_load) begin
            r_count <= w_close ? '0 : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_close <= w_close;
        end
    end

    // One lane per axis.
    logic signed [SAMPLE_W-1:0] w_raw [MAX_AXES];
    t_lane_hit                  w_hit [AXES];

    assign w_raw[0] = i_sample.x_sample;
    assign w_raw[1] = i_sample.y_sample;
    assign w_raw[2] = i_sample.z_sample;

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        ammd_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_s1_load  (w_s1_load),
            .i_s1_close (w_close),
            .i_raw      (w_raw[a]),
            .i_s2_load  (w_s2_load),
            .i_s2_close (r_s1_close),
            .i_limits   (r_limits),
            .o_hit      (w_hit[a])
        );
    end

    // Merge the lanes into the result word.
    t_result w_result;

    ammd_merge #(
        .AXES (AXES)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_s2_load),
        .i_close  (r_s1_close),
        .i_hit    (w_hit),
        .o_result (w_result)
    );

    assign o_result.valid         = r_out_valid;
    assign o_result.motion_state  = w_result.motion_state;
    assign o_result.crossing_seen = w_result.crossing_seen;
    assign o_result.period_end    = w_result.period_end;

endmodule
